### src/ipc_pkg.sv
// Shared types and constants for the IPv4 packet classifier.
package ipc_pkg;

  localparam int LENGTH_BITS  = 25;
  localparam int COUNTER_BITS = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = 2;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] DNS_PORT       = 16'd53;

  typedef enum logic [2:0] {
    CLS_TRUNC      = 3'd0,
    CLS_NON_IPV4   = 3'd1,
    CLS_TRUNC_IPV4 = 3'd2,
    CLS_BAD_IPV4   = 3'd3,
    CLS_TCP        = 3'd4,
    CLS_UDP        = 3'd5,
    CLS_ICMP       = 3'd6,
    CLS_OTHER_IP   = 3'd7
  } class_t;

  // One classified frame as it passes from the parser to the counter stage.
  typedef struct packed {
    class_t                   cls;
    logic [31:0]              src_addr;
    logic [31:0]              dst_addr;
    logic                     addr_ok;
    logic [15:0]              src_port;
    logic [15:0]              dst_port;
    logic                     port_ok;
    logic                     dns;
    logic [LENGTH_BITS-1:0]   len;
  } frame_info_t;

endpackage

### src/ipc_parser.sv
// Front part: parses frame bytes and classifies each finished frame.
module ipc_parser import ipc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_valid,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty_frame,
  output logic        info_valid,
  output frame_info_t info
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [LENGTH_BITS-1:0] pos_r, pos_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [5:0]  hdr_r, hdr_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt, dst_r, dst_nxt;
  logic [15:0] sport_r, sport_nxt, dport_r, dport_nxt, flags_r, flags_nxt;
  logic [LENGTH_BITS:0] nlp_r, nlp_nxt;
  logic nonempty_r, nonempty_nxt, ended_r, ended_nxt, bad_r, bad_nxt;

  logic                 take;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS:0] t, lenw, p;
  class_t               cls;
  logic                 dns;

  always_comb begin
    pos_nxt = pos_r; etype_nxt = etype_r; hdr_nxt = hdr_r; proto_nxt = proto_r;
    src_nxt = src_r; dst_nxt = dst_r; sport_nxt = sport_r; dport_nxt = dport_r;
    flags_nxt = flags_r; nlp_nxt = nlp_r; nonempty_nxt = nonempty_r;
    ended_nxt = ended_r; bad_nxt = bad_r;
    take = byte_valid && !empty_frame && (pos_r != LEN_MAX);
    p = {1'b0, pos_r};
    t = (LENGTH_BITS+1)'(14) + {{(LENGTH_BITS-5){1'b0}}, hdr_r};
    if (take) begin
      pos_nxt = pos_r + 1'b1;
      if (p == 12 || p == 13) etype_nxt = {etype_r[7:0], data_byte};
      if (p == 14) begin
        hdr_nxt = {data_byte[3:0], 2'b00};
        nlp_nxt = (LENGTH_BITS+1)'(34) + {{(LENGTH_BITS-5){1'b0}}, data_byte[3:0], 2'b00};
      end else if (p > 14) begin
        if (p == 23) proto_nxt = data_byte;
        if (p >= 26 && p <= 29) src_nxt = {src_r[23:0], data_byte};
        if (p >= 30 && p <= 33) dst_nxt = {dst_r[23:0], data_byte};
        if (p == t || p == t + 1) sport_nxt = {sport_r[7:0], data_byte};
        if (p == t + 2 || p == t + 3) dport_nxt = {dport_r[7:0], data_byte};
        if (p == t + 10 || p == t + 11) flags_nxt = {flags_r[7:0], data_byte};
        if (p == nlp_r && !ended_r && !bad_r) begin
          if (data_byte == 8'd0) ended_nxt = 1'b1;
          else if (data_byte[7:6] != 2'b00) bad_nxt = 1'b1;
          else begin
            nonempty_nxt = 1'b1;
            nlp_nxt = p + 1'b1 + {{(LENGTH_BITS-7){1'b0}}, data_byte};
          end
        end
      end
    end
    // Classification sees the state including this request's byte.
    len  = pos_nxt;
    lenw = {1'b0, len};
    t    = (LENGTH_BITS+1)'(14) + {{(LENGTH_BITS-5){1'b0}}, hdr_nxt};
    if (lenw < 14) cls = CLS_TRUNC;
    else if (etype_nxt != ETHERTYPE_IPV4) cls = CLS_NON_IPV4;
    else if (lenw < 34) cls = CLS_TRUNC_IPV4;
    else if (hdr_nxt < 6'd20 || lenw < t) cls = CLS_BAD_IPV4;
    else if (proto_nxt == PROTO_TCP && lenw >= t + 4) cls = CLS_TCP;
    else if (proto_nxt == PROTO_UDP && lenw >= t + 8) cls = CLS_UDP;
    else if (proto_nxt == PROTO_ICMP) cls = CLS_ICMP;
    else cls = CLS_OTHER_IP;
    dns = (cls == CLS_UDP) && (sport_nxt == DNS_PORT || dport_nxt == DNS_PORT) &&
          (lenw >= t + 20) && !flags_nxt[15] && nonempty_nxt && !bad_nxt &&
          (ended_nxt || nlp_nxt <= lenw);
  end

  logic frame_end;
  assign frame_end = byte_valid && (empty_frame || last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n || frame_end) begin
      pos_r <= '0; etype_r <= '0; hdr_r <= '0; proto_r <= '0; src_r <= '0;
      dst_r <= '0; sport_r <= '0; dport_r <= '0; flags_r <= '0; nlp_r <= '0;
      nonempty_r <= 1'b0; ended_r <= 1'b0; bad_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; etype_r <= etype_nxt; hdr_r <= hdr_nxt; proto_r <= proto_nxt;
      src_r <= src_nxt; dst_r <= dst_nxt; sport_r <= sport_nxt; dport_r <= dport_nxt;
      flags_r <= flags_nxt; nlp_r <= nlp_nxt; nonempty_r <= nonempty_nxt;
      ended_r <= ended_nxt; bad_r <= bad_nxt;
    end
  end

  logic addr_ok, port_ok;
  assign addr_ok = cls[2];
  assign port_ok = (cls == CLS_TCP) || (cls == CLS_UDP);

  always_ff @(posedge clk) begin
    if (!rst_n) info_valid <= 1'b0;
    else info_valid <= frame_end;
    info.cls      <= cls;
    info.src_addr <= addr_ok ? src_nxt : '0;
    info.dst_addr <= addr_ok ? dst_nxt : '0;
    info.addr_ok  <= addr_ok;
    info.src_port <= port_ok ? sport_nxt : '0;
    info.dst_port <= port_ok ? dport_nxt : '0;
    info.port_ok  <= port_ok;
    info.dns      <= dns;
    info.len      <= len;
  end

  assert property (@(posedge clk) disable iff (!rst_n) info_valid && info.dns |-> info.port_ok)
    else $error("dns flag without ports");
  assert property (@(posedge clk) disable iff (!rst_n)
    info_valid |-> (info.addr_ok == info.cls[2]))
    else $error("address valid mismatches class");
  assert property (@(posedge clk) disable iff (!rst_n) $past(frame_end) |-> pos_r == '0)
    else $error("frame state not cleared");

endmodule

### src/ipc_queue.sv
// Short queue between the parser and the counter stage.
module ipc_queue import ipc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  frame_info_t wr_data,
  input  logic        rd_en,
  output frame_info_t rd_data,
  output logic        q_empty,
  output logic [QUEUE_AW:0] q_count
);

  frame_info_t mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
    end
  end

  assign rd_data = mem[rp_r];
  assign q_empty = (cnt_r == '0);
  assign q_count = cnt_r;

  assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> !q_empty)
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !rd_en |-> cnt_r != (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

### src/ipc_counters.sv
// Back part: updates frame, byte and class counters and holds the result register.
module ipc_counters import ipc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  frame_info_t q_data,
  output logic        q_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output frame_info_t out_info,
  output logic [COUNTER_BITS-1:0] out_class_total,
  output logic [COUNTER_BITS-1:0] out_frame_total,
  output logic [COUNTER_BITS-1:0] out_byte_total
);

  logic [COUNTER_BITS-1:0] frame_cnt_r, byte_cnt_r;
  logic [COUNTER_BITS-1:0] class_cnt_r [8];
  logic                    full_r;
  logic [COUNTER_BITS-1:0] class_new;

  // The output register takes a new request when it is empty or being drained.
  assign q_pop     = !q_empty && (!full_r || out_pop);
  assign out_empty = !full_r;
  assign class_new = class_cnt_r[q_data.cls] + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      frame_cnt_r <= '0;
      byte_cnt_r <= '0;
      for (int i = 0; i < 8; i++) class_cnt_r[i] <= '0;
    end else begin
      if (q_pop) begin
        full_r <= 1'b1;
        frame_cnt_r <= frame_cnt_r + 1'b1;
        byte_cnt_r <= byte_cnt_r + COUNTER_BITS'(q_data.len);
        class_cnt_r[q_data.cls] <= class_new;
      end else if (out_pop) begin
        full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_info        <= q_data;
      out_class_total <= class_new;
      out_frame_total <= frame_cnt_r + 1'b1;
      out_byte_total  <= byte_cnt_r + COUNTER_BITS'(q_data.len);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> full_r)
    else $error("result not held");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_frame_total == frame_cnt_r)
    else $error("frame total mismatch");
  assert property (@(posedge clk) disable iff (!rst_n) full_r && !out_pop |-> !q_pop)
    else $error("held result overwritten");

endmodule

### src/ipv4_packet_classifier.sv
// Top level of the IPv4 packet classifier.
//   channel   direction  handshake        payload
//   in_       request    push / full      data_byte, last_byte, empty_frame
//   out_      result     pop / empty      class, addresses, ports, dns, length, totals
// One byte is taken per cycle while full is low; a result passes the parser's output
// register, the queue and the counter stage's output register in that order.
// Reset (rst_n low, synchronous) clears all parse state and counters.
// full rises only when the four-entry queue cannot absorb a result in flight;
// out_pop stalls just the counter stage, the parser keeps running until the queue fills.
module ipv4_packet_classifier import ipc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        in_empty_frame,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  out_class_code,
  output logic [31:0] out_source_address,
  output logic [31:0] out_dest_address,
  output logic        out_addresses_valid,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic        out_ports_valid,
  output logic        out_dns_query,
  output logic [LENGTH_BITS-1:0]  out_frame_length,
  output logic [COUNTER_BITS-1:0] out_class_total,
  output logic [COUNTER_BITS-1:0] out_frame_total,
  output logic [COUNTER_BITS-1:0] out_byte_total
);

  logic        accept, info_valid, q_empty, q_pop;
  frame_info_t info, q_data, out_info;
  logic [QUEUE_AW:0] q_count;

  // Keep room for the entry already in the parser's output register.
  assign full   = (q_count + (QUEUE_AW+1)'(info_valid)) >= (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign accept = push && !full;

  ipc_parser u_parser (
    .clk, .rst_n,
    .byte_valid(accept), .data_byte(in_data_byte), .last_byte(in_last_byte),
    .empty_frame(in_empty_frame), .info_valid, .info
  );

  ipc_queue u_queue (
    .clk, .rst_n, .wr_en(info_valid), .wr_data(info), .rd_en(q_pop),
    .rd_data(q_data), .q_empty, .q_count
  );

  ipc_counters u_counters (
    .clk, .rst_n, .q_empty, .q_data, .q_pop, .out_pop(pop), .out_empty(empty),
    .out_info, .out_class_total, .out_frame_total, .out_byte_total
  );

  assign out_class_code      = out_info.cls;
  assign out_source_address  = out_info.src_addr;
  assign out_dest_address    = out_info.dst_addr;
  assign out_addresses_valid = out_info.addr_ok;
  assign out_source_port     = out_info.src_port;
  assign out_dest_port       = out_info.dst_port;
  assign out_ports_valid     = out_info.port_ok;
  assign out_dns_query       = out_info.dns;
  assign out_frame_length    = out_info.len;

endmodule
